// ===== hw/rtl/rotation_matrix_to_quaternion_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Assert that a condition implies another in the same cycle.
`define RMQ_ASSERT_IMP(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Assert that a condition implies another in the next cycle.
`define RMQ_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/rmq_pkg.sv =====
// Package with widths, types and helpers of the matrix to quaternion block.
package rmq_pkg;
    localparam int DATA_WIDTH = 20;
    localparam int FRAC_BITS  = 16;
    localparam int CAND_W     = DATA_WIDTH + 3;
    localparam int DIFF_W     = DATA_WIDTH + 1;
    // Radicand of the root: candidate shifted left by FRAC_BITS-2.
    localparam int RAD_W      = CAND_W + FRAC_BITS - 2;
    localparam int ROOT_W     = (RAD_W + 1) / 2;
    // Numerator of the scale quotient: doubled magnitude shifted.
    localparam int NUM_W      = DIFF_W + FRAC_BITS;
    localparam int QUO_W      = NUM_W;
    localparam int OUT_TDATA_W = ((4 * DATA_WIDTH + 7) / 8) * 8;
    localparam int IN_TDATA_W  = ((9 * DATA_WIDTH + 7) / 8) * 8;
    localparam int DIV_LAT    = NUM_W;

    typedef enum logic [1:0] {
        SEL_X = 2'd0,
        SEL_Y = 2'd1,
        SEL_Z = 2'd2,
        SEL_W = 2'd3
    } sel_t;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    function automatic data_t sat_out(input logic signed [QUO_W+1:0] v);
        logic signed [QUO_W+1:0] hi;
        logic signed [QUO_W+1:0] lo;
        hi = (QUO_W+2)'((64'sd1 <<< (DATA_WIDTH-1)) - 64'sd1);
        lo = -(QUO_W+2)'(64'sd1 <<< (DATA_WIDTH-1));
        if (v > hi) return data_t'(hi);
        if (v < lo) return data_t'(lo);
        return data_t'(v);
    endfunction
endpackage

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata: m00..m22, 20 bits each
//  m_      | out | m_tvalid/m_tready | m_tdata: qx,qy,qz,qw; m_tuser: degenerate
//
// One item enters per cycle while m_ is not stalled. The path holds 2 front stages, 19
// square root stages, 37 divider stages and 1 output register; the bit-per-stage root and divider set the depth.
// Reset (aresetn low, synchronous) clears every valid bit.
// A stall on m_ freezes the whole pipeline; nothing is dropped or repeated.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // qx, qy, qz, qw from the lowest bit up.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // degenerate.
    output logic                   m_tuser
);
    // The pipeline advances when the output slot is empty or being taken.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic                     f_valid;
    sel_t                     f_sel;
    logic                     f_degen;
    logic [CAND_W-1:0]        f_cand;
    logic signed [DIFF_W-1:0] f_d0, f_d1, f_d2;

    rmq_front u_front (
        .aclk, .aresetn, .en,
        .in_valid (s_tvalid && s_tready),
        .in_data  (s_tdata),
        .out_valid(f_valid), .out_sel(f_sel), .out_degen(f_degen),
        .out_cand (f_cand), .out_d0(f_d0), .out_d1(f_d1), .out_d2(f_d2)
    );

    // The candidate times 2^(FRAC_BITS-2) is the radicand.
    localparam int SW = 3 * DIFF_W + 3;
    logic [RAD_W-1:0]  rad;
    logic [SW-1:0]     side_in, side_out;
    logic              r_valid;
    logic [ROOT_W-1:0] root;
    assign rad     = {f_cand, (FRAC_BITS-2)'(0)};
    assign side_in = {f_degen, f_sel, f_d2, f_d1, f_d0};

    rmq_sqrt u_sqrt (
        .aclk, .aresetn, .en,
        .in_valid(f_valid), .in_rad(rad), .in_side(side_in),
        .out_valid(r_valid), .out_root(root), .out_side(side_out)
    );

    logic signed [DIFF_W-1:0] sd [3];
    sel_t                     r_sel;
    logic                     r_degen;
    assign sd[0]   = side_out[DIFF_W-1:0];
    assign sd[1]   = side_out[2*DIFF_W-1:DIFF_W];
    assign sd[2]   = side_out[3*DIFF_W-1:2*DIFF_W];
    assign r_sel   = sel_t'(side_out[3*DIFF_W+1:3*DIFF_W]);
    assign r_degen = side_out[3*DIFF_W+2];

    // Three dividers compute round(|d| * 2^(FRAC_BITS-2) / v) as
    // floor((2*|d|*2^(FRAC_BITS-2) + v) / (2v)).
    logic [QUO_W-1:0] quo [3];
    for (genvar j = 0; j < 3; j++) begin : g_div
        logic [DIFF_W-1:0] mag;
        logic [NUM_W-1:0]  num;
        assign mag = sd[j][DIFF_W-1] ? DIFF_W'(-sd[j]) : DIFF_W'(sd[j]);
        assign num = {1'b0, mag, (FRAC_BITS-1)'(0)} + NUM_W'(root);
        rmq_div u_div (
            .aclk, .en,
            .in_num(num), .in_den({root, 1'b0}), .out_quo(quo[j])
        );
    end

    // Side data delayed alongside the dividers.
    localparam int DL = DIV_LAT;
    logic              dv_reg   [DL];
    logic [3:0]        dneg_reg [DL];
    sel_t              dsel_reg [DL];
    logic              ddeg_reg [DL];
    logic [ROOT_W-1:0] droot_reg[DL];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DL; i++) dv_reg[i] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= r_valid;
            for (int i = 1; i < DL; i++) dv_reg[i] <= dv_reg[i-1];
        end
        if (en) begin
            dneg_reg[0]  <= {1'b0, sd[2][DIFF_W-1], sd[1][DIFF_W-1], sd[0][DIFF_W-1]};
            dsel_reg[0]  <= r_sel;
            ddeg_reg[0]  <= r_degen;
            droot_reg[0] <= root;
            for (int i = 1; i < DL; i++) begin
                dneg_reg[i]  <= dneg_reg[i-1];
                dsel_reg[i]  <= dsel_reg[i-1];
                ddeg_reg[i]  <= ddeg_reg[i-1];
                droot_reg[i] <= droot_reg[i-1];
            end
        end
    end

    // Saturate, apply sign, and route to component slots.
    data_t c [3];
    data_t vq;
    for (genvar j = 0; j < 3; j++) begin : g_sat
        logic signed [QUO_W+1:0] w;
        assign w = dneg_reg[DL-1][j] ? -$signed({2'b00, quo[j]}) : $signed({2'b00, quo[j]});
        assign c[j] = sat_out(w);
    end
    assign vq = sat_out($signed({2'b00, QUO_W'(droot_reg[DL-1])}));

    data_t qx, qy, qz, qw;
    always_comb begin
        unique case (dsel_reg[DL-1])
            SEL_X:   begin qx = vq;   qy = c[0]; qz = c[1]; qw = c[2]; end
            SEL_Y:   begin qx = c[0]; qy = vq;   qz = c[1]; qw = c[2]; end
            SEL_Z:   begin qx = c[0]; qy = c[1]; qz = vq;   qw = c[2]; end
            default: begin qx = c[0]; qy = c[1]; qz = c[2]; qw = vq;   end
        endcase
        if (ddeg_reg[DL-1]) begin
            qx = '0; qy = '0; qz = '0; qw = '0;
        end
    end

    logic                   ov_reg;
    logic [OUT_TDATA_W-1:0] od_reg;
    logic                   ou_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= dv_reg[DL-1];
        end
        if (en) begin
            od_reg <= OUT_TDATA_W'({qw, qz, qy, qx});
            ou_reg <= ddeg_reg[DL-1];
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;
endmodule

// ===== hw/rtl/rmq_front.sv =====
// Candidate forming, largest pick and off-diagonal terms, two register stages.
module rmq_front
    import rmq_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [IN_TDATA_W-1:0]         in_data,
    output logic                          out_valid,
    output sel_t                          out_sel,
    output logic                          out_degen,
    output logic [CAND_W-1:0]             out_cand,
    output logic signed [DIFF_W-1:0]      out_d0,
    output logic signed [DIFF_W-1:0]      out_d1,
    output logic signed [DIFF_W-1:0]      out_d2
);
    data_t m [9];
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            m[i] = data_t'(in_data[i*DATA_WIDTH +: DATA_WIDTH]);
        end
    end

    // Stage 1: candidates and the six off-diagonal terms.
    logic                     v1_reg;
    logic signed [CAND_W-1:0] c_reg [4];
    logic signed [DIFF_W-1:0] s01_reg, s02_reg, s12_reg, d12_reg, d20_reg, d01_reg;
    logic signed [CAND_W-1:0] a0, a1, a2, one;
    assign a0  = CAND_W'(m[0]);
    assign a1  = CAND_W'(m[4]);
    assign a2  = CAND_W'(m[8]);
    assign one = CAND_W'(1) <<< FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            c_reg[0] <= a0 - a1 - a2 + one;
            c_reg[1] <= -a0 + a1 - a2 + one;
            c_reg[2] <= -a0 - a1 + a2 + one;
            c_reg[3] <= a0 + a1 + a2 + one;
            s01_reg  <= DIFF_W'(m[3]) + DIFF_W'(m[1]);
            s02_reg  <= DIFF_W'(m[2]) + DIFF_W'(m[6]);
            s12_reg  <= DIFF_W'(m[7]) + DIFF_W'(m[5]);
            d12_reg  <= DIFF_W'(m[7]) - DIFF_W'(m[5]);
            d20_reg  <= DIFF_W'(m[2]) - DIFF_W'(m[6]);
            d01_reg  <= DIFF_W'(m[3]) - DIFF_W'(m[1]);
        end
    end

    // Stage 2: pick the largest candidate, first wins ties.
    sel_t                     best;
    logic signed [CAND_W-1:0] bc;
    always_comb begin
        best = SEL_X;
        bc   = c_reg[0];
        if (c_reg[1] > bc) begin best = SEL_Y; bc = c_reg[1]; end
        if (c_reg[2] > bc) begin best = SEL_Z; bc = c_reg[2]; end
        if (c_reg[3] > bc) begin best = SEL_W; bc = c_reg[3]; end
    end

    logic                     v2_reg;
    sel_t                     sel_reg;
    logic                     degen_reg;
    logic [CAND_W-1:0]        cand_reg;
    logic signed [DIFF_W-1:0] d0_reg, d1_reg, d2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            sel_reg   <= best;
            degen_reg <= (bc <= 0);
            cand_reg  <= (bc <= 0) ? '0 : bc;
            unique case (best)
                SEL_X: begin d0_reg <= s01_reg; d1_reg <= s02_reg; d2_reg <= d12_reg; end
                SEL_Y: begin d0_reg <= s01_reg; d1_reg <= s12_reg; d2_reg <= d20_reg; end
                SEL_Z: begin d0_reg <= s02_reg; d1_reg <= s12_reg; d2_reg <= d01_reg; end
                default: begin d0_reg <= d12_reg; d1_reg <= d20_reg; d2_reg <= d01_reg; end
            endcase
        end
    end

    assign out_valid = v2_reg;
    assign out_sel   = sel_reg;
    assign out_degen = degen_reg;
    assign out_cand  = cand_reg;
    assign out_d0    = d0_reg;
    assign out_d1    = d1_reg;
    assign out_d2    = d2_reg;
endmodule

// ===== hw/rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with side data.
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [RAD_W-1:0]         in_rad,
    input  logic [3*DIFF_W+3-1:0]    in_side,
    output logic                     out_valid,
    output logic [ROOT_W-1:0]        out_root,
    output logic [3*DIFF_W+3-1:0]    out_side
);
    localparam int RW = 2 * ROOT_W;
    localparam int SW = 3 * DIFF_W + 3;

    logic            v_reg    [ROOT_W+1];
    logic [RW-1:0]   rem_reg  [ROOT_W+1];
    logic [RW-1:0]   rad_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg [ROOT_W+1];
    logic [SW-1:0]   side_reg [ROOT_W+1];

    always_comb begin
        v_reg[0]    = in_valid;
        rem_reg[0]  = '0;
        rad_reg[0]  = RW'(in_rad);
        root_reg[0] = '0;
        side_reg[0] = in_side;
    end

    // Restoring root: each stage brings down two radicand bits.
    for (genvar k = 0; k < ROOT_W; k++) begin : g_st
        logic [RW+1:0] r2;
        logic [RW+1:0] t;
        assign r2 = {rem_reg[k], rad_reg[k][RW-1 -: 2]};
        assign t  = {(RW+2-ROOT_W-2)'(0), root_reg[k], 2'b01};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
            if (en) begin
                if (r2 >= t) begin
                    rem_reg[k+1]  <= RW'(r2 - t);
                    root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k+1]  <= RW'(r2);
                    root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b0};
                end
                rad_reg[k+1]  <= rad_reg[k] << 2;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];
endmodule

// ===== hw/rtl/rmq_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rmq_div
    import rmq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic [NUM_W-1:0]      in_num,
    input  logic [ROOT_W:0]       in_den,
    output logic [QUO_W-1:0]      out_quo
);
    localparam int DW = ROOT_W + 2;

    logic [NUM_W-1:0] num_reg [NUM_W+1];
    logic [DW-1:0]    rem_reg [NUM_W+1];
    logic [ROOT_W:0]  den_reg [NUM_W+1];
    logic [QUO_W-1:0] quo_reg [NUM_W+1];

    always_comb begin
        num_reg[0] = in_num;
        rem_reg[0] = '0;
        den_reg[0] = in_den;
        quo_reg[0] = '0;
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_st
        logic [DW-1:0] r2;
        assign r2 = {rem_reg[k][DW-2:0], num_reg[k][NUM_W-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (r2 >= DW'(den_reg[k])) begin
                    rem_reg[k+1] <= r2 - DW'(den_reg[k]);
                    quo_reg[k+1] <= {quo_reg[k][QUO_W-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= r2;
                    quo_reg[k+1] <= {quo_reg[k][QUO_W-2:0], 1'b0};
                end
                num_reg[k+1] <= num_reg[k] << 1;
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign out_quo = quo_reg[NUM_W];
endmodule

// ===== hw/rtl/rmq_checker.sv =====
// Port-level checker for the converter, bound to the top level.
`include "rotation_matrix_to_quaternion_defines.svh"
module rmq_props
    import rmq_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);
    `RMQ_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
    `RMQ_ASSERT_IMP(a_degen_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0, "degenerate item not zero")
    `RMQ_ASSERT_IMP(a_ready, aclk, aresetn, !m_tvalid, s_tready, "input blocked with empty output")
endmodule

bind rotation_matrix_to_quaternion rmq_props u_rmq_props (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
